// ===== hdl/bcgr_pkg.sv =====
package bcgr_pkg;

    localparam int NUM_BUFFERS = 16;
    localparam int IDX_W       = 4;
    localparam int CNT_W       = 5;
    localparam int BLOCK_BITS  = 16;

    typedef enum logic [1:0] {
        ACT_GET     = 2'd0,
        ACT_REL     = 2'd1,
        ACT_REL_DLY = 2'd2,
        ACT_NONE    = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_HIT      = 3'd0,
        ST_MISS     = 3'd1,
        ST_BUSY     = 3'd2,
        ST_NOFREE   = 3'd3,
        ST_WB       = 3'd4,
        ST_RELEASED = 3'd5,
        ST_NOTFOUND = 3'd6,
        ST_RSVD     = 3'd7
    } status_t;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_SCAN,
        SEQ_ACT,
        SEQ_WALK
    } seq_state_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] block_number;
    } in_beat_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  buffer_index;
        logic [15:0] block_tag;
        logic        last;
    } out_beat_t;

endpackage

// ===== hdl/buffer_cache_getblk_release_core.sv =====
// A request scans buffer headers one per cycle up to the first match, then
// takes a decision step in SEQ_ACT; a get miss then walks the free list in SEQ_WALK,
// giving one beat per written-back buffer and then the grant or no-free beat.
// One request at a time: the input stalls until the sequencer is idle again, and a
// stalled output beat holds the sequencer in SEQ_ACT or SEQ_WALK.
// Reset (rst_n low, async): all buffers invalid, unlocked, clean, free in index order.
module buffer_cache_getblk_release_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  bcgr_pkg::in_beat_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output bcgr_pkg::out_beat_t out_data
);

    localparam int NB = bcgr_pkg::NUM_BUFFERS;
    localparam int IW = bcgr_pkg::IDX_W;
    localparam int CW = bcgr_pkg::CNT_W;
    localparam int BB = bcgr_pkg::BLOCK_BITS;

    // buffer header state
    logic [BB-1:0] tag_reg     [NB];
    logic [BB-1:0] tag_next    [NB];
    logic [NB-1:0] valid_reg, valid_next;
    logic [NB-1:0] locked_reg, locked_next;
    logic [NB-1:0] delayed_reg, delayed_next;
    logic [NB-1:0] onlist_reg, onlist_next;
    logic [IW-1:0] fnext_reg   [NB];
    logic [IW-1:0] fnext_next  [NB];
    logic [IW-1:0] fprev_reg   [NB];
    logic [IW-1:0] fprev_next  [NB];
    logic [IW-1:0] head_reg, head_next;
    logic [IW-1:0] tail_reg, tail_next;
    logic [CW-1:0] count_reg, count_next;

    // sequencer
    bcgr_pkg::seq_state_t state_reg, state_next;
    logic [1:0]    act_reg, act_next;
    logic [BB-1:0] blk_reg, blk_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic          found_reg, found_next;
    logic [CW-1:0] n_reg, n_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    logic                out_vld_reg, out_vld_next;
    bcgr_pkg::out_beat_t out_reg, out_next;

    logic          can_emit;
    logic          unl_en, app_en;
    logic [IW-1:0] unl_idx, app_idx;
    logic [IW-1:0] up, un;

    assign can_emit  = !out_vld_reg || !out_stall;
    assign out_valid = out_vld_reg;
    assign out_data  = out_reg;
    assign in_stall  = (state_reg != bcgr_pkg::SEQ_IDLE);

    always_comb
    begin
        tag_next     = tag_reg;
        valid_next   = valid_reg;
        locked_next  = locked_reg;
        delayed_next = delayed_reg;
        onlist_next  = onlist_reg;
        fnext_next   = fnext_reg;
        fprev_next   = fprev_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        count_next   = count_reg;
        state_next   = state_reg;
        act_next     = act_reg;
        blk_next     = blk_reg;
        idx_next     = idx_reg;
        found_next   = found_reg;
        n_next       = n_reg;
        cnt_next     = cnt_reg;
        out_vld_next = out_vld_reg && out_stall;
        out_next     = out_reg;
        unl_en       = 1'b0;
        unl_idx      = idx_reg;
        app_en       = 1'b0;
        app_idx      = idx_reg;
        up           = '0;
        un           = '0;

        unique case (state_reg)
            bcgr_pkg::SEQ_IDLE:
            begin
                if (in_valid && in_data.action != bcgr_pkg::ACT_NONE)
                begin
                    act_next   = in_data.action;
                    blk_next   = in_data.block_number[BB-1:0];
                    idx_next   = '0;
                    found_next = 1'b0;
                    state_next = bcgr_pkg::SEQ_SCAN;
                end
            end
            bcgr_pkg::SEQ_SCAN:
            begin
                // shared comparator: one header per cycle, first match wins
                if (valid_reg[idx_reg] && tag_reg[idx_reg] == blk_reg)
                begin
                    found_next = 1'b1;
                    state_next = bcgr_pkg::SEQ_ACT;
                end
                else if (idx_reg == IW'(NB - 1))
                begin
                    state_next = bcgr_pkg::SEQ_ACT;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            bcgr_pkg::SEQ_ACT:
            begin
                if (act_reg == bcgr_pkg::ACT_GET && !found_reg)
                begin
                    idx_next   = head_reg;
                    n_next     = '0;
                    cnt_next   = count_reg;
                    state_next = bcgr_pkg::SEQ_WALK;
                end
                else if (can_emit)
                begin
                    out_vld_next           = 1'b1;
                    out_next.last          = 1'b1;
                    out_next.block_tag     = '0;
                    out_next.buffer_index  = idx_reg;
                    state_next             = bcgr_pkg::SEQ_IDLE;
                    if (act_reg == bcgr_pkg::ACT_GET)
                    begin
                        if (locked_reg[idx_reg])
                        begin
                            out_next.status = bcgr_pkg::ST_BUSY;
                        end
                        else
                        begin
                            locked_next[idx_reg] = 1'b1;
                            unl_en          = 1'b1;
                            out_next.status = bcgr_pkg::ST_HIT;
                        end
                    end
                    else if (!found_reg)
                    begin
                        out_next.status       = bcgr_pkg::ST_NOTFOUND;
                        out_next.buffer_index = '0;
                    end
                    else
                    begin
                        if (act_reg == bcgr_pkg::ACT_REL_DLY)
                        begin
                            delayed_next[idx_reg] = 1'b1;
                        end
                        if (locked_reg[idx_reg])
                        begin
                            locked_next[idx_reg] = 1'b0;
                            app_en = 1'b1;
                        end
                        out_next.status = bcgr_pkg::ST_RELEASED;
                    end
                end
            end
            bcgr_pkg::SEQ_WALK:
            begin
                if (can_emit)
                begin
                    out_vld_next          = 1'b1;
                    out_next.buffer_index = idx_reg;
                    if (n_reg < cnt_reg)
                    begin
                        if (delayed_reg[idx_reg])
                        begin
                            // write back, clear the mark, advance along the list
                            out_next.status       = bcgr_pkg::ST_WB;
                            out_next.block_tag    = tag_reg[idx_reg];
                            out_next.last         = 1'b0;
                            delayed_next[idx_reg] = 1'b0;
                            idx_next              = fnext_reg[idx_reg];
                            n_next                = n_reg + 1'b1;
                        end
                        else
                        begin
                            out_next.status      = bcgr_pkg::ST_MISS;
                            out_next.block_tag   = tag_reg[idx_reg];
                            out_next.last        = 1'b1;
                            unl_en               = 1'b1;
                            tag_next[idx_reg]    = blk_reg;
                            valid_next[idx_reg]  = 1'b1;
                            locked_next[idx_reg] = 1'b1;
                            state_next           = bcgr_pkg::SEQ_IDLE;
                        end
                    end
                    else
                    begin
                        out_next.status       = bcgr_pkg::ST_NOFREE;
                        out_next.buffer_index = '0;
                        out_next.block_tag    = '0;
                        out_next.last         = 1'b1;
                        state_next            = bcgr_pkg::SEQ_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = bcgr_pkg::SEQ_IDLE;
            end
        endcase

        // drop a buffer from the free list
        if (unl_en && onlist_reg[unl_idx] && count_reg != '0)
        begin
            up = fprev_reg[unl_idx];
            un = fnext_reg[unl_idx];
            if (count_reg == CW'(1))
            begin
                head_next = '0;
                tail_next = '0;
            end
            else
            begin
                if (unl_idx == head_reg)
                    head_next = un;
                else
                    fnext_next[up] = un;
                if (unl_idx == tail_reg)
                    tail_next = up;
                else
                    fprev_next[un] = up;
            end
            onlist_next[unl_idx] = 1'b0;
            count_next           = count_reg - 1'b1;
        end

        // append a buffer at the free-list tail
        if (app_en && !onlist_reg[app_idx])
        begin
            if (count_reg == '0)
            begin
                head_next = app_idx;
            end
            else
            begin
                fnext_next[tail_reg] = app_idx;
                fprev_next[app_idx]  = tail_reg;
            end
            tail_next            = app_idx;
            onlist_next[app_idx] = 1'b1;
            count_next           = count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NB; i++)
            begin
                tag_reg[i]   <= '0;
                fnext_reg[i] <= IW'((i + 1) % NB);
                fprev_reg[i] <= IW'((i + NB - 1) % NB);
            end
            valid_reg   <= '0;
            locked_reg  <= '0;
            delayed_reg <= '0;
            onlist_reg  <= '1;
            head_reg    <= '0;
            tail_reg    <= IW'(NB - 1);
            count_reg   <= CW'(NB);
            state_reg   <= bcgr_pkg::SEQ_IDLE;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            tag_reg     <= tag_next;
            fnext_reg   <= fnext_next;
            fprev_reg   <= fprev_next;
            valid_reg   <= valid_next;
            locked_reg  <= locked_next;
            delayed_reg <= delayed_next;
            onlist_reg  <= onlist_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            count_reg   <= count_next;
            state_reg   <= state_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        act_reg   <= act_next;
        blk_reg   <= blk_next;
        idx_reg   <= idx_next;
        found_reg <= found_next;
        n_reg     <= n_next;
        cnt_reg   <= cnt_next;
        out_reg   <= out_next;
    end

endmodule

// ===== hdl/bcgr_checker.sv =====
module bcgr_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input bcgr_pkg::in_beat_t  in_data,
    input logic                out_valid,
    input logic                out_stall,
    input bcgr_pkg::out_beat_t out_data
);

    // a real request closes the input until its beats are out
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && in_data.action != bcgr_pkg::ACT_NONE |=> in_stall)
        else $error("input not closed after request");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled output beat changed");

    a_wb_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status == bcgr_pkg::ST_WB |-> !out_data.last)
        else $error("writeback beat marked last");

    a_final_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != bcgr_pkg::ST_WB |-> out_data.last)
        else $error("final beat not marked last");

    // input reopens only after the last beat has been produced
    a_open_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(in_stall) |-> $past(out_valid) || out_valid)
        else $error("input reopened without a result");

endmodule

bind buffer_cache_getblk_release_core bcgr_checker u_bcgr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

// ===== verif/tb_buffer_cache_getblk_release_core.sv =====
`timescale 1ns / 1ps

module tb_buffer_cache_getblk_release_core;

    localparam int NBUF = bcgr_pkg::NUM_BUFFERS;

    // Shadow copy of the buffer headers and the free list; updated once per
    // accepted request beat and used to predict the result beats.
    class cache_scoreboard;
        logic [15:0] tag [NBUF];
        bit          valid [NBUF];
        bit          locked [NBUF];
        bit          dirty [NBUF];
        int          nxt [NBUF];
        int          prv [NBUF];
        bit          on_list [NBUF];
        int          head;
        int          tail;
        int          nfree;
        bcgr_pkg::out_beat_t pending [$];
        int          errors;

        function new();
            errors = 0;
            for (int i = 0; i < NBUF; i++)
            begin
                tag[i] = '0;
                valid[i] = 0;
                locked[i] = 0;
                dirty[i] = 0;
                nxt[i] = (i + 1 < NBUF) ? i + 1 : 0;
                prv[i] = (i == 0) ? NBUF - 1 : i - 1;
                on_list[i] = 1;
            end
            head = 0;
            tail = NBUF - 1;
            nfree = NBUF;
        endfunction

        function int find_block(logic [15:0] blk);
            for (int i = 0; i < NBUF; i++)
                if (valid[i] && tag[i] == blk)
                    return i;
            return -1;
        endfunction

        function void unlink(int i);
            int p;
            int n;
            if (!on_list[i] || nfree == 0)
                return;
            p = prv[i];
            n = nxt[i];
            if (nfree == 1)
            begin
                head = 0;
                tail = 0;
            end
            else
            begin
                if (i == head) head = n; else nxt[p] = n;
                if (i == tail) tail = p; else prv[n] = p;
            end
            on_list[i] = 0;
            nfree--;
        endfunction

        function void append(int i);
            if (on_list[i])
                return;
            if (nfree == 0)
            begin
                head = i;
                tail = i;
            end
            else
            begin
                nxt[tail] = i;
                prv[i] = tail;
                tail = i;
            end
            on_list[i] = 1;
            nfree++;
        endfunction

        function void push(bcgr_pkg::status_t st, int idx, logic [15:0] t);
            bcgr_pkg::out_beat_t b;
            b.status = st;
            b.buffer_index = idx[3:0];
            b.block_tag = t;
            b.last = 1'b0;
            pending.push_back(b);
        endfunction

        // Note an accepted request and queue the beats it must produce.
        function void note_request(bcgr_pkg::in_beat_t rq);
            int f;
            int p;
            int cnt;
            int first;
            bit got;
            logic [15:0] old;
            if (rq.action == bcgr_pkg::ACT_NONE)
                return;
            first = pending.size();
            f = find_block(rq.block_number);
            if (rq.action == bcgr_pkg::ACT_GET)
            begin
                if (f >= 0 && locked[f])
                    push(bcgr_pkg::ST_BUSY, f, '0);
                else if (f >= 0)
                begin
                    locked[f] = 1;
                    unlink(f);
                    push(bcgr_pkg::ST_HIT, f, '0);
                end
                else
                begin
                    p = head;
                    cnt = nfree;
                    got = 0;
                    for (int n = 0; n < cnt && n < NBUF; n++)
                    begin
                        if (dirty[p])
                        begin
                            push(bcgr_pkg::ST_WB, p, tag[p]);
                            dirty[p] = 0;
                            p = nxt[p];
                        end
                        else
                        begin
                            old = tag[p];
                            unlink(p);
                            tag[p] = rq.block_number;
                            valid[p] = 1;
                            locked[p] = 1;
                            push(bcgr_pkg::ST_MISS, p, old);
                            got = 1;
                            break;
                        end
                    end
                    if (!got)
                        push(bcgr_pkg::ST_NOFREE, 0, '0);
                end
            end
            else if (f < 0)
                push(bcgr_pkg::ST_NOTFOUND, 0, '0);
            else
            begin
                if (rq.action == bcgr_pkg::ACT_REL_DLY)
                    dirty[f] = 1;
                if (locked[f])
                begin
                    locked[f] = 0;
                    append(f);
                end
                push(bcgr_pkg::ST_RELEASED, f, '0);
            end
            if (pending.size() > first)
                pending[pending.size() - 1].last = 1'b1;
        endfunction

        // Check one accepted result beat against the oldest expectation.
        function void check_result(bcgr_pkg::out_beat_t got);
            bcgr_pkg::out_beat_t want;
            if (pending.size() == 0)
            begin
                report_mismatch($sformatf("unexpected beat %h", got));
                return;
            end
            want = pending.pop_front();
            if (got.status !== want.status)
                report_mismatch($sformatf("status %0d want %0d", got.status, want.status));
            if (got.buffer_index !== want.buffer_index)
                report_mismatch($sformatf("index %0d want %0d",
                                          got.buffer_index, want.buffer_index));
            if (got.block_tag !== want.block_tag)
                report_mismatch($sformatf("tag %h want %h", got.block_tag, want.block_tag));
            if (got.last !== want.last)
                report_mismatch($sformatf("last %b want %b", got.last, want.last));
        endfunction

        function void report_mismatch(string msg);
            $display("MISMATCH @%0t: %s", $realtime, msg);
            errors++;
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    bcgr_pkg::in_beat_t  in_data;
    logic                out_valid;
    logic                out_stall;
    bcgr_pkg::out_beat_t out_data;

    cache_scoreboard board;
    logic [15:0]     recent [$];

    buffer_cache_getblk_release_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Note every accepted beat on both channels at the edge where it moves.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            board.note_request(in_data);
        if (rst_n && out_valid && !out_stall)
            board.check_result(out_data);
    end

    // Draw a stall pattern for the result side; after a little over a third of the
    // accepted result beats no back-pressure follows at all.
    initial
    begin
        int gap;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 12);
                if (gap > 0)
                begin
                    out_stall <= 1'b1;
                    repeat (gap) @(posedge clk);
                    out_stall <= 1'b0;
                end
            end
        end
    end

    // Send one request beat, then hold until it is taken.
    task automatic send_request(bcgr_pkg::action_t act, logic [15:0] blk, int gap);
        repeat (gap) @(posedge clk);
        in_valid <= 1'b1;
        in_data.action <= act;
        in_data.block_number <= blk;
        do @(posedge clk); while (in_stall);
        in_valid <= 1'b0;
        if (act == bcgr_pkg::ACT_GET)
            recent.push_back(blk);
        if (recent.size() > 24)
            void'(recent.pop_front());
    endtask

    // Pick a block mostly from the recently used set, so hits, busy answers
    // and releases of held buffers dominate; the rest are fresh numbers.
    function automatic logic [15:0] pick_block();
        if (recent.size() > 0 && $urandom_range(0, 3) != 0)
            return recent[$urandom_range(0, recent.size() - 1)];
        return 16'($urandom);
    endfunction

    function automatic int pick_gap();
        return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
    endfunction

    initial
    begin
        bcgr_pkg::action_t act;
        int      r;
        board = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: fill every buffer, exhaust the list, release with and
        // without the delayed mark, then miss to force write-backs.
        send_request(bcgr_pkg::ACT_REL, 16'h0000, 0);
        for (int i = 0; i < 16; i++)
            send_request(bcgr_pkg::ACT_GET, (i == 0) ? 16'h0000 : 16'hFFF0 + 16'(i), 0);
        send_request(bcgr_pkg::ACT_GET, 16'hFFFF, 1);
        send_request(bcgr_pkg::ACT_GET, 16'hFFF1, 0);
        send_request(bcgr_pkg::ACT_REL_DLY, 16'hFFF1, 2);
        send_request(bcgr_pkg::ACT_REL_DLY, 16'hFFF2, 0);
        send_request(bcgr_pkg::ACT_GET, 16'hFFF2, 0);
        send_request(bcgr_pkg::ACT_REL, 16'hFFF2, 0);
        send_request(bcgr_pkg::ACT_REL_DLY, 16'hFFF2, 0);
        send_request(bcgr_pkg::ACT_NONE, 16'hAAAA, 0);
        send_request(bcgr_pkg::ACT_GET, 16'h5555, 3);
        send_request(bcgr_pkg::ACT_REL, 16'h1234, 0);

        // Random: mostly gets and releases of cached blocks, some noise.
        for (int n = 0; n < 180; n++)
        begin
            r = $urandom_range(0, 19);
            if (r < 9) act = bcgr_pkg::ACT_GET;
            else if (r < 14) act = bcgr_pkg::ACT_REL;
            else if (r < 19) act = bcgr_pkg::ACT_REL_DLY;
            else act = bcgr_pkg::ACT_NONE;
            send_request(act, pick_block(), pick_gap());
        end

        // let the monitor note the last request before draining
        @(posedge clk);
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (board.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Watchdog: ends the run with an error if the requests and their stalls never finish.
    initial
    begin
        #400000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
